// ----- rtl/core/itra_pkg.sv -----
// Package: shared constants, command/status structs and the digit-to-ASCII function.
`timescale 1ns / 1ps
package itra_pkg;

   localparam int RADIX_W = 5;
   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic shift;
      logic emit_sign;
      logic emit_digit;
   } itra_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic radix_ok;
      logic last_bit;
      logic need_sign;
      logic last_digit;
   } itra_sts_type;

   // One digit (0..15) as upper-case ASCII
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] code;
      if (d < 4'd10) begin
         code = CHAR_ZERO + {4'd0, d};
      end else begin
         code = CHAR_A + {4'd0, d} - 8'd10;
      end
      return code;
   endfunction

endpackage

// ----- rtl/core/itra_if.sv -----
// Interfaces: request word channel and response character channel.
`timescale 1ns / 1ps
interface itra_req_if #(parameter int WIDTH = 32) ();
   logic                    valid;
   logic                    ready;
   logic signed [WIDTH-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface itra_rsp_if ();
   logic                        valid;
   logic                        ready;
   logic [itra_pkg::CHAR_W-1:0] character;
   logic                        last_char;

   modport source (output valid, output character, output last_char, input ready);
   modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ----- rtl/core/itra_dp.sv -----
// Datapath: magnitude shifter, radix digit cells, digit pointer and response register.
`timescale 1ns / 1ps
module itra_dp #(
   parameter int W = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  itra_pkg::itra_cmd_type        cmd,
   output itra_pkg::itra_sts_type        sts,
   input  logic [itra_pkg::RADIX_W-1:0]  radix,
   input  logic signed [W-1:0]           req_number,
   output logic [itra_pkg::CHAR_W-1:0]   rsp_character,
   output logic                          rsp_last_char
);
   import itra_pkg::*;

   localparam int PW = $clog2(W);
   localparam logic [PW-1:0] LAST_IDX = PW'(W - 1);

   logic [W-1:0]         mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [PW-1:0]        cnt_ff, cnt_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [DIGIT_W-1:0]   digit_ff [W];
   logic [DIGIT_W-1:0]   digit_in [W];
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   logic [W-1:0]         gen, prop, kill_n;
   logic [W:0]           csum, cin;
   logic [W-1:0]         co;
   logic [RADIX_W-1:0]   cell_tmp [W];

   // Per-cell generate/propagate of the doubling carry
   always_comb begin
      for (int i = 0; i < W; i++) begin
         gen[i]  = ({digit_ff[i], 1'b0} >= radix);
         prop[i] = ({digit_ff[i], 1'b1} == radix);
      end
      kill_n = gen | prop;
   end

   // Carry chain across the cells as one add, shifted-in bit as carry in
   assign csum = {1'b0, kill_n} + {1'b0, gen} + {{W{1'b0}}, mag_ff[W-1]};
   assign cin  = csum ^ {1'b0, kill_n} ^ {1'b0, gen};
   assign co   = cin[W:1];

   // New cell values: 2d + carry_in, minus radix on carry out
   always_comb begin
      for (int i = 0; i < W; i++) begin
         cell_tmp[i] = {digit_ff[i], cin[i]} - (co[i] ? radix : {RADIX_W{1'b0}});
      end
   end

   // Next-state selection
   always_comb begin
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      char_in = char_ff;
      last_in = last_ff;
      for (int i = 0; i < W; i++) begin
         digit_in[i] = digit_ff[i];
      end
      if (cmd.load) begin
         neg_in = req_number[W-1];
         mag_in = req_number[W-1] ? (~req_number + W'(1)) : req_number;
         cnt_in = '0;
         pos_in = '0;
         for (int i = 0; i < W; i++) begin
            digit_in[i] = '0;
         end
      end else if (cmd.shift) begin
         mag_in = {mag_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + PW'(1);
         pos_in = pos_ff + PW'(co[pos_ff]);
         for (int i = 0; i < W; i++) begin
            digit_in[i] = cell_tmp[i][DIGIT_W-1:0];
         end
      end else if (cmd.emit_sign) begin
         char_in = CHAR_MINUS;
         last_in = 1'b0;
      end else if (cmd.emit_digit) begin
         char_in = digit_char(digit_ff[pos_ff]);
         last_in = (pos_ff == '0);
         pos_in  = pos_ff - PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
      for (int i = 0; i < W; i++) begin
         digit_ff[i] <= digit_in[i];
      end
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   // Status to the controller
   always_comb begin
      sts.radix_ok   = radix inside {[RADIX_MIN:RADIX_MAX]};
      sts.last_bit   = (cnt_ff == LAST_IDX);
      sts.need_sign  = neg_ff && (radix == RADIX_DEC);
      sts.last_digit = (pos_ff == '0);
   end

   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ----- rtl/core/itra_ctrl.sv -----
// Controller: sequences load, conversion shifts, sign and digit emission.
`timescale 1ns / 1ps
module itra_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output itra_pkg::itra_cmd_type cmd,
   input  itra_pkg::itra_sts_type sts
);
   import itra_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_SIGN  = 4'b0100,
      ST_DIGIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      slot_free;
   logic      emit;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !valid_ff || rsp_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.radix_ok) begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            cmd.shift = 1'b1;
            if (sts.last_bit) begin
               state_in = sts.need_sign ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.last_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on emit, cleared when the word is taken
   assign emit     = cmd.emit_sign || cmd.emit_digit;
   assign valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

   // Never overwrite a response word that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> (!valid_ff || rsp_ready))
      else $error("response word overwritten");

   // Last digit ends the item and frees the input
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && sts.last_digit) |=> (state_ff == ST_IDLE))
      else $error("no return to idle after last digit");

   // Bad radix: item dropped, no conversion started
   a_bad_radix: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !sts.radix_ok) |=> (state_ff == ST_IDLE && !emit))
      else $error("conversion started with radix out of range");

endmodule

// ----- rtl/core/integer_to_radix_ascii_top.sv -----
// Top level: radix register, controller and datapath of the integer to ASCII converter.
// Operation: a word is accepted in idle, then the conversion state shifts its magnitude,
// one bit per shift, into the radix digit cells; the sign or first digit is then
// emitted into the response register. Throughput: one character per cycle while
// the response side is ready.
// Reset (synchronous, active high) returns to idle, drops any pending character
// and sets the radix to ten.
`timescale 1ns / 1ps
module integer_to_radix_ascii_top #(
   parameter int INPUT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   itra_req_if.sink                      req,
   itra_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic [itra_pkg::RADIX_W-1:0]  csr_wr_data
);
   import itra_pkg::*;

   logic [RADIX_W-1:0] radix_ff, radix_in;
   itra_cmd_type       cmd;
   itra_sts_type       sts;
   logic               req_ready;
   logic               rsp_valid;

   // Radix register
   assign radix_in = csr_wr_en ? csr_wr_data : radix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   itra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   itra_dp #(
      .W (INPUT_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .radix         (radix_ff),
      .req_number    (INPUT_WIDTH'(req.number)),
      .rsp_character (rsp.character),
      .rsp_last_char (rsp.last_char)
   );

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;

endmodule
